[rtl/core/percent_decode_field_splitter_top_defines.svh]
// Assertion macros for the field splitter
`ifndef PERCENT_DECODE_FIELD_SPLITTER_TOP_DEFINES_SVH
`define PERCENT_DECODE_FIELD_SPLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PDFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdfs check failed");
`define PDFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdfs check failed");
`else
`define PDFS_ASSERT_NOW(label, ante, cons)
`define PDFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/core/pdfs_pkg.sv]
package pdfs_pkg;

  localparam int FIELD_CAP     = 64;
  localparam int FIELD_LEN_CAP = 65536;

  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;

  localparam logic CFG_MAX_FIELDS      = 1'b0;
  localparam logic CFG_MAX_FIELD_BYTES = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic [5:0] field_index;
    logic       end_of_field;
    logic       end_of_packet;
    logic [6:0] field_count;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0]  pending_count;
    logic [7:0]  pending_digit;
    logic        field_open;
    logic        swallow_separator;
    logic [15:0] field_fill;
    logic [6:0]  fields_done;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic vld;
    out_t res;
  } step_t;

endpackage

[rtl/core/percent_decode_field_splitter_top.sv]
// Percent-decoding field splitter.
// Input channel (in_valid/in_stall/in_data): one packet byte per transaction,
// or an end marker that closes the packet. Output channel
// (out_valid/out_stall/out_data): one result per transaction, with last set
// on the final result caused by an input transaction.
// Configuration (cfg_we/cfg_index/cfg_wdata): index 0 is max_fields,
// index 1 is max_field_bytes; write only while the block is idle.
// The first result of a transaction is offered in the cycle after it is
// accepted. Each input transaction makes zero to three results, all built
// together into a four-entry result buffer, which drains one result per
// cycle when out_stall is low. An input transaction is taken in every cycle
// in which the buffer is empty or is handing over its final result, so
// single-result traffic runs at one transaction per cycle without stalls.
// A stalled receiver holds the current result and, through in_stall, the
// input side. Reset (rst_n low, synchronous) empties the buffer, clears all
// per-packet state and loads max_fields 16 and max_field_bytes 255.
`include "percent_decode_field_splitter_top_defines.svh"

module percent_decode_field_splitter_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pdfs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pdfs_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_wdata
);

  import pdfs_pkg::*;

  localparam logic [6:0]  FIELD_CAP_W = 7'(FIELD_CAP);
  localparam logic [15:0] LEN_MAX_W   = 16'(FIELD_LEN_CAP - 1);

  logic [6:0]  max_fields_r;
  logic [15:0] max_field_bytes_r;
  st_t         state_r, state_nxt;
  out_t        buf_r [4];
  out_t        slot_nxt [4];
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  rd_r;
  logic [6:0]  eff_fields;
  logic [15:0] eff_len;
  logic        acc, pop;

  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[CH_0:CH_9]}) r = {1'b1, 4'(c - CH_0)};
    else if (c inside {[CH_UA:CH_UF]}) r = {1'b1, 4'(c - CH_UA + 8'd10)};
    else if (c inside {[CH_LA:CH_LF]}) r = {1'b1, 4'(c - CH_LA + 8'd10)};
    return r;
  endfunction

  function automatic step_t emit_byte(st_t s, logic [7:0] b, logic [15:0] len);
    step_t      r;
    logic [16:0] fp1;
    logic        full;
    r = '0;
    r.st = s;
    fp1 = {1'b0, s.field_fill} + 17'd1;
    full = fp1 >= {1'b0, len};
    r.vld = 1'b1;
    r.res.data_byte = b;
    r.res.has_byte = 1'b1;
    r.res.field_index = s.fields_done[5:0];
    r.res.end_of_field = full;
    r.st.field_fill = fp1[15:0];
    if (full) begin
      r.st.fields_done = s.fields_done + 7'd1;
      r.st.field_open = 1'b0;
      r.st.field_fill = '0;
      r.st.swallow_separator = 1'b1;
    end
    return r;
  endfunction

  function automatic step_t plain_byte(st_t s, logic [7:0] c, logic [15:0] len,
                                       logic [6:0] nf);
    step_t r;
    logic  ign;
    r = '0;
    r.st = s;
    ign = 1'b0;
    if (s.swallow_separator) begin
      r.st.swallow_separator = 1'b0;
      if (c == CH_PIPE) ign = 1'b1;
    end
    if (!ign && !r.st.field_open) begin
      if (r.st.fields_done >= nf) begin
        ign = 1'b1;
      end else begin
        r.st.field_open = 1'b1;
        r.st.field_fill = '0;
      end
    end
    if (!ign) begin
      if (c == CH_PIPE) begin
        r.vld = 1'b1;
        r.res.field_index = r.st.fields_done[5:0];
        r.res.end_of_field = 1'b1;
        r.st.fields_done = r.st.fields_done + 7'd1;
        r.st.field_open = 1'b0;
        r.st.field_fill = '0;
      end else if (c == CH_PCT) begin
        r.st.pending_count = 2'd1;
      end else begin
        r = emit_byte(r.st, c, len);
      end
    end
    return r;
  endfunction

  always_comb begin
    eff_fields = (max_fields_r > FIELD_CAP_W) ? FIELD_CAP_W : max_fields_r;
    if (max_field_bytes_r == '0) eff_len = 16'd1;
    else if (32'(max_field_bytes_r) > FIELD_LEN_CAP - 1) eff_len = LEN_MAX_W;
    else eff_len = max_field_bytes_r;
  end

  always_comb begin
    st_t        cur;
    step_t      t;
    logic [1:0] pc;
    logic [7:0] d;
    logic [4:0] hc, hd;
    out_t       e;
    cur = state_r;
    t = '0;
    cnt_nxt = '0;
    for (int i = 0; i < 4; i++) slot_nxt[i] = '0;
    pc = cur.pending_count;
    d = cur.pending_digit;
    hc = hex_of(in_data.in_byte);
    hd = hex_of(d);
    e = '0;
    if (in_data.end_marker) begin
      cur.pending_count = '0;
      cur.pending_digit = '0;
      if (pc != 2'd0) begin
        t = emit_byte(cur, CH_PCT, eff_len);
        cur = t.st;
        slot_nxt[cnt_nxt[1:0]] = t.res;
        cnt_nxt = cnt_nxt + 3'd1;
      end
      if (pc == 2'd2) begin
        t = plain_byte(cur, d, eff_len, eff_fields);
        cur = t.st;
        if (t.vld) begin
          slot_nxt[cnt_nxt[1:0]] = t.res;
          cnt_nxt = cnt_nxt + 3'd1;
        end
      end
      e.end_of_packet = 1'b1;
      if (cur.field_open) begin
        e.field_index = cur.fields_done[5:0];
        e.end_of_field = 1'b1;
        e.field_count = cur.fields_done + 7'd1;
      end else begin
        e.field_count = cur.fields_done;
      end
      slot_nxt[cnt_nxt[1:0]] = e;
      cnt_nxt = cnt_nxt + 3'd1;
      cur = '0;
    end else if (pc == 2'd1 && hc[4]) begin
      cur.pending_count = 2'd2;
      cur.pending_digit = in_data.in_byte;
    end else if (pc == 2'd2 && hc[4] && hd[4]) begin
      cur.pending_count = '0;
      cur.pending_digit = '0;
      t = emit_byte(cur, {hd[3:0], hc[3:0]}, eff_len);
      cur = t.st;
      slot_nxt[0] = t.res;
      cnt_nxt = 3'd1;
    end else begin
      cur.pending_count = '0;
      cur.pending_digit = '0;
      if (pc != 2'd0) begin
        t = emit_byte(cur, CH_PCT, eff_len);
        cur = t.st;
        slot_nxt[cnt_nxt[1:0]] = t.res;
        cnt_nxt = cnt_nxt + 3'd1;
      end
      if (pc == 2'd2) begin
        t = plain_byte(cur, d, eff_len, eff_fields);
        cur = t.st;
        if (t.vld) begin
          slot_nxt[cnt_nxt[1:0]] = t.res;
          cnt_nxt = cnt_nxt + 3'd1;
        end
      end
      t = plain_byte(cur, in_data.in_byte, eff_len, eff_fields);
      cur = t.st;
      if (t.vld) begin
        slot_nxt[cnt_nxt[1:0]] = t.res;
        cnt_nxt = cnt_nxt + 3'd1;
      end
    end
    if (cnt_nxt != 3'd0) slot_nxt[2'(cnt_nxt - 3'd1)].last = 1'b1;
    state_nxt = cur;
  end

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = buf_r[rd_r];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall));
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r      <= 7'd16;
      max_field_bytes_r <= 16'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FIELDS:      max_fields_r <= cfg_wdata[6:0];
        CFG_MAX_FIELD_BYTES: max_field_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      cnt_r   <= '0;
      rd_r    <= '0;
    end else if (acc) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= '0;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 4; i++) buf_r[i] <= slot_nxt[i];
    end
  end

  `PDFS_ASSERT_NOW(a_last_matches_count, out_valid, out_data.last == (cnt_r == 3'd1))
  `PDFS_ASSERT_NOW(a_accept_only_when_drained, acc, cnt_r == 3'd0 || pop)
  `PDFS_ASSERT_NOW(a_eop_is_last, out_valid && out_data.end_of_packet, out_data.last)
  `PDFS_ASSERT_NEXT(a_eop_clears_state, acc && in_data.end_marker, state_r == '0)

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pdfs_pkg::*;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_t         item;
    bit          typed;
    out_t        want;
    logic        cfg_idx;
    logic [15:0] cfg_val;
  } stim_row_t;

  typedef struct {
    int fields;
    int bytes;
    int idle_pct;
    int stall_pct;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  // splitter state mirror
  logic [1:0]  esc_cnt;
  logic [7:0]  esc_digit;
  logic        fld_open;
  logic        swallow_bar;
  logic [15:0] fld_fill;
  logic [6:0]  flds_done;
  logic [6:0]  lim_fields;
  logic [15:0] lim_bytes;

  out_t step_res[$];
  out_t expected_results[$];
  stim_row_t stim_table[$];

  percent_decode_field_splitter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int hex_val(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic int eff_fields();
    return (int'(lim_fields) > FIELD_CAP) ? FIELD_CAP : int'(lim_fields);
  endfunction

  function automatic int eff_len();
    int v;
    v = int'(lim_bytes);
    if (v == 0) v = 1;
    if (v > FIELD_LEN_CAP - 1) v = FIELD_LEN_CAP - 1;
    return v;
  endfunction

  function automatic out_t mk_res(logic [7:0] d, logic has, logic [5:0] idx, logic eof,
                                  logic eop, logic [6:0] cnt);
    out_t r;
    r.data_byte = d;
    r.has_byte = has;
    r.field_index = idx;
    r.end_of_field = eof;
    r.end_of_packet = eop;
    r.field_count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_res(logic [7:0] d, logic has, logic [5:0] idx, logic eof,
                                  logic eop, logic [6:0] cnt);
    out_t r;
    if (step_res.size() >= 4) return;
    r = mk_res(d, has, idx, eof, eop, cnt);
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    bit full;
    full = (int'(fld_fill) + 1) >= eff_len();
    add_res(b, 1'b1, flds_done[5:0], full, 1'b0, 7'd0);
    fld_fill = fld_fill + 16'd1;
    if (full) begin
      flds_done = flds_done + 7'd1;
      fld_open = 1'b0;
      fld_fill = '0;
      swallow_bar = 1'b1;
    end
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (swallow_bar) begin
      swallow_bar = 1'b0;
      if (c == CH_PIPE) return;
    end
    if (!fld_open) begin
      if (int'(flds_done) >= eff_fields()) return;
      fld_open = 1'b1;
      fld_fill = '0;
    end
    if (c == CH_PIPE) begin
      add_res(8'd0, 1'b0, flds_done[5:0], 1'b1, 1'b0, 7'd0);
      flds_done = flds_done + 7'd1;
      fld_open = 1'b0;
      fld_fill = '0;
    end else if (c == CH_PCT) begin
      esc_cnt = 2'd1;
    end else begin
      emit_byte(c);
    end
  endfunction

  function automatic void flush_escape();
    logic [1:0] n;
    logic [7:0] d;
    n = esc_cnt;
    d = esc_digit;
    esc_cnt = '0;
    esc_digit = '0;
    if (n >= 2'd1) emit_byte(CH_PCT);
    if (n >= 2'd2) plain_byte(d);
  endfunction

  function automatic void clear_packet();
    esc_cnt = '0;
    esc_digit = '0;
    fld_open = 1'b0;
    swallow_bar = 1'b0;
    fld_fill = '0;
    flds_done = '0;
  endfunction

  // computes the results of one accepted byte or end marker
  function automatic void split_decode(in_t x);
    logic [6:0] idx;
    int lo;
    int hi;
    step_res.delete();
    if (x.end_marker) begin
      flush_escape();
      if (fld_open) begin
        idx = flds_done;
        flds_done = flds_done + 7'd1;
        add_res(8'd0, 1'b0, idx[5:0], 1'b1, 1'b1, flds_done);
      end else begin
        add_res(8'd0, 1'b0, 6'd0, 1'b0, 1'b1, flds_done);
      end
      clear_packet();
    end else if (esc_cnt == 2'd1) begin
      if (hex_val(x.in_byte) >= 0) begin
        esc_cnt = 2'd2;
        esc_digit = x.in_byte;
      end else begin
        flush_escape();
        plain_byte(x.in_byte);
      end
    end else if (esc_cnt == 2'd2) begin
      lo = hex_val(x.in_byte);
      hi = hex_val(esc_digit);
      if (lo >= 0 && hi >= 0) begin
        esc_cnt = '0;
        esc_digit = '0;
        emit_byte(8'((hi << 4) | lo));
      end else begin
        flush_escape();
        plain_byte(x.in_byte);
      end
    end else begin
      esc_cnt = '0;
      plain_byte(x.in_byte);
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, data_byte", int'(out_data.data_byte), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.data_byte !== want.data_byte)
          report_mismatch("data_byte", int'(out_data.data_byte), int'(want.data_byte));
        if (out_data.has_byte !== want.has_byte)
          report_mismatch("has_byte", int'(out_data.has_byte), int'(want.has_byte));
        if (out_data.field_index !== want.field_index)
          report_mismatch("field_index", int'(out_data.field_index),
                          int'(want.field_index));
        if (out_data.end_of_field !== want.end_of_field)
          report_mismatch("end_of_field", int'(out_data.end_of_field),
                          int'(want.end_of_field));
        if (out_data.end_of_packet !== want.end_of_packet)
          report_mismatch("end_of_packet", int'(out_data.end_of_packet),
                          int'(want.end_of_packet));
        if (out_data.field_count !== want.field_count)
          report_mismatch("field_count", int'(out_data.field_count),
                          int'(want.field_count));
        if (out_data.last !== want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  function automatic in_t mk_byte(logic [7:0] b);
    in_t x;
    x.in_byte = b;
    x.end_marker = 1'b0;
    return x;
  endfunction

  function automatic in_t mk_end();
    in_t x;
    x.in_byte = 8'($urandom_range(255));
    x.end_marker = 1'b1;
    return x;
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  task automatic send_item(in_t x, bit typed, out_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_stall);
    split_decode(x);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (step_res[i]) expected_results.push_back(step_res[i]);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_MAX_FIELDS) lim_fields = val[6:0];
    else lim_bytes = val;
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic void row_byte(logic [7:0] b);
    stim_row_t r;
    r = '{kind: ROW_ITEM, item: mk_byte(b), typed: 1'b0, want: '0, cfg_idx: 1'b0,
          cfg_val: '0};
    stim_table.push_back(r);
  endfunction

  function automatic void row_typed(in_t x, out_t want);
    stim_row_t r;
    r = '{kind: ROW_ITEM, item: x, typed: 1'b1, want: want, cfg_idx: 1'b0, cfg_val: '0};
    stim_table.push_back(r);
  endfunction

  function automatic void row_cfg(logic idx, logic [15:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, item: '0, typed: 1'b0, want: '0, cfg_idx: idx, cfg_val: val};
    stim_table.push_back(r);
  endfunction

  // one random token: plain byte, good escape, broken escape, separator or end
  task automatic send_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_item(mk_byte(8'($urandom_range(255))), 1'b0, '0);
    end else if (pick < 65) begin
      send_item(mk_byte(CH_PCT), 1'b0, '0);
      send_item(mk_byte(rand_hex()), 1'b0, '0);
      send_item(mk_byte(rand_hex()), 1'b0, '0);
    end else if (pick < 73) begin
      send_item(mk_byte(CH_PCT), 1'b0, '0);
      if ($urandom_range(1)) send_item(mk_byte(rand_hex()), 1'b0, '0);
      if ($urandom_range(2) == 0) send_item(mk_end(), 1'b0, '0);
      else send_item(mk_byte(8'($urandom_range(255))), 1'b0, '0);
    end else if (pick < 88) begin
      send_item(mk_byte(CH_PIPE), 1'b0, '0);
    end else begin
      send_item(mk_end(), 1'b0, '0);
    end
  endtask

  initial begin
    phase_t phases[7];
    int start;

    lim_fields = 7'd16;
    lim_bytes = 16'd255;
    clear_packet();

    row_typed(mk_end(), mk_res(8'd0, 1'b0, 6'd0, 1'b0, 1'b1, 7'd0));
    row_typed(mk_byte(8'h41), mk_res(8'h41, 1'b1, 6'd0, 1'b0, 1'b0, 7'd0));
    row_typed(mk_byte(8'h00), mk_res(8'h00, 1'b1, 6'd0, 1'b0, 1'b0, 7'd0));
    row_typed(mk_byte(8'hFF), mk_res(8'hFF, 1'b1, 6'd0, 1'b0, 1'b0, 7'd0));
    row_typed(mk_byte(CH_PIPE), mk_res(8'd0, 1'b0, 6'd0, 1'b1, 1'b0, 7'd0));
    row_typed(mk_byte(CH_PIPE), mk_res(8'd0, 1'b0, 6'd1, 1'b1, 1'b0, 7'd0));
    row_byte(CH_PCT); row_byte(CH_LA); row_byte(CH_UF);
    row_byte(CH_PCT); row_byte(8'h67);
    row_byte(CH_PCT); row_byte(8'h33); row_byte(CH_PIPE);
    row_byte(CH_PCT); row_byte(8'h37); row_typed(mk_end(), '0);
    stim_table[stim_table.size() - 1].typed = 1'b0;
    // one byte per field, two fields, separator after a full field swallowed
    row_cfg(CFG_MAX_FIELD_BYTES, 16'd0);
    row_cfg(CFG_MAX_FIELDS, 16'd2);
    row_typed(mk_byte(8'h78), mk_res(8'h78, 1'b1, 6'd0, 1'b1, 1'b0, 7'd0));
    row_byte(CH_PIPE);
    row_typed(mk_byte(8'h79), mk_res(8'h79, 1'b1, 6'd1, 1'b1, 1'b0, 7'd0));
    row_byte(8'h7A);
    row_typed(mk_end(), mk_res(8'd0, 1'b0, 6'd0, 1'b0, 1'b1, 7'd2));
    // field length lowered while a field is open
    row_cfg(CFG_MAX_FIELD_BYTES, 16'hFFFF);
    row_cfg(CFG_MAX_FIELDS, 16'h007F);
    row_byte(8'h61); row_byte(8'h62);
    row_cfg(CFG_MAX_FIELD_BYTES, 16'd1);
    row_typed(mk_byte(8'h63), mk_res(8'h63, 1'b1, 6'd0, 1'b1, 1'b0, 7'd0));
    row_typed(mk_end(), mk_res(8'd0, 1'b0, 6'd0, 1'b0, 1'b1, 7'd1));
    row_cfg(CFG_MAX_FIELDS, 16'd0);
    row_byte(8'h71);
    row_typed(mk_end(), mk_res(8'd0, 1'b0, 6'd0, 1'b0, 1'b1, 7'd0));

    phases[0] = '{16, 255, 0, 0};
    phases[1] = '{2, 1, 87, 0};
    phases[2] = '{64, 3, 0, 87};
    phases[3] = '{127, 65535, 33, 33};
    phases[4] = '{1, 4, 0, 0};
    phases[5] = '{100, 0, 87, 0};
    phases[6] = '{5, 2, 0, 87};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        write_cfg(stim_table[i].cfg_idx, stim_table[i].cfg_val);
      end else begin
        send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      end
    end

    foreach (phases[p]) begin
      write_cfg(CFG_MAX_FIELDS, 16'(phases[p].fields));
      write_cfg(CFG_MAX_FIELD_BYTES, 16'(phases[p].bytes));
      idle_pct = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      start = items_sent;
      while (items_sent - start < 9) send_token();
      // hold off the sender until the output side has caught up
      drain();
      while (items_sent - start < 18) send_token();
      send_item(mk_end(), 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d byte/end transactions and checked %0d results", items_sent,
             results_seen);
    $display("across %0d register writes with idle and stall mixes", cfg_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pdfs_pkg.sv
rtl/core/percent_decode_field_splitter_top.sv
bench/tb_top.sv
